// ===== hw/rtl/mpfd_pkg.sv =====
package mpfd_pkg;

   localparam int PAGE_ROWS   = 8;
   localparam int COORD_W     = 8;
   localparam int INDEX_W     = 10;
   localparam int WIDE_ADDR_W = 14;
   localparam int ERR_W       = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [2:0] REQ_FILL    = 3'd0;
   localparam logic [2:0] REQ_PIXEL   = 3'd1;
   localparam logic [2:0] REQ_LINE    = 3'd2;
   localparam logic [2:0] REQ_OUTLINE = 3'd3;
   localparam logic [2:0] REQ_SOLID   = 3'd4;
   localparam logic [2:0] REQ_READ    = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_FILL,
      OP_PIXEL,
      OP_LINE,
      OP_OUTLINE,
      OP_SOLID,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ,
      ST_RESP
   } eng_state_type;

   typedef struct packed {
      op_type               op;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COORD_W-1:0]   xe;
      logic [COORD_W-1:0]   ye;
      logic [COORD_W-1:0]   w;
      logic [COORD_W-1:0]   h;
      logic                 on;
      logic [7:0]           pat;
      logic [INDEX_W-1:0]   ridx;
      logic [COORD_W-1:0]   dx;
      logic [COORD_W-1:0]   dym;
      logic                 sx_neg;
      logic                 sy_neg;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== hw/rtl/mpfd_front.sv =====
module mpfd_front #(
   parameter int STORE_SIZE = 1024
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_type,
   input  logic [7:0]                  req_start_x,
   input  logic [7:0]                  req_start_y,
   input  logic [7:0]                  req_end_x,
   input  logic [7:0]                  req_end_y,
   input  logic [7:0]                  req_rect_width,
   input  logic [7:0]                  req_rect_height,
   input  logic                        req_pixel_on,
   input  logic [7:0]                  req_fill_pattern,
   input  logic [9:0]                  req_read_index,
   input  mpfd_pkg::q_status_type      q_status,
   input  logic                        clearing,
   output logic                        push,
   output mpfd_pkg::cmd_type           cmd
);

   logic size_ok;
   logic index_ok;

   assign req_stall = q_status.full || clearing;
   assign push      = req_valid && !req_stall;
   assign size_ok   = (req_rect_width != 8'd0) && (req_rect_height != 8'd0);
   assign index_ok  = 32'(req_read_index) < STORE_SIZE;

   always_comb begin
      cmd.x      = req_start_x;
      cmd.y      = req_start_y;
      cmd.xe     = req_end_x;
      cmd.ye     = req_end_y;
      cmd.w      = req_rect_width;
      cmd.h      = req_rect_height;
      cmd.on     = req_pixel_on;
      cmd.pat    = req_fill_pattern;
      cmd.ridx   = req_read_index;
      cmd.dx     = (req_end_x > req_start_x) ? (req_end_x - req_start_x)
                                             : (req_start_x - req_end_x);
      cmd.dym    = (req_end_y > req_start_y) ? (req_end_y - req_start_y)
                                             : (req_start_y - req_end_y);
      cmd.sx_neg = !(req_start_x < req_end_x);
      cmd.sy_neg = !(req_start_y < req_end_y);
      unique case (req_type)
         mpfd_pkg::REQ_FILL:    cmd.op = mpfd_pkg::OP_FILL;
         mpfd_pkg::REQ_PIXEL:   cmd.op = mpfd_pkg::OP_PIXEL;
         mpfd_pkg::REQ_LINE:    cmd.op = mpfd_pkg::OP_LINE;
         mpfd_pkg::REQ_OUTLINE: cmd.op = size_ok ? mpfd_pkg::OP_OUTLINE : mpfd_pkg::OP_NONE;
         mpfd_pkg::REQ_SOLID:   cmd.op = size_ok ? mpfd_pkg::OP_SOLID : mpfd_pkg::OP_NONE;
         mpfd_pkg::REQ_READ:    cmd.op = index_ok ? mpfd_pkg::OP_READ : mpfd_pkg::OP_NONE;
         default:               cmd.op = mpfd_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== hw/rtl/mpfd_queue.sv =====
module mpfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mpfd_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output mpfd_pkg::cmd_type      pop_cmd,
   output mpfd_pkg::q_status_type q_status
);

   mpfd_pkg::cmd_type          entries_ff [mpfd_pkg::QUEUE_DEPTH];
   logic [mpfd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mpfd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mpfd_pkg::QPTR_W:0]   count_ff, count_in;

   assign pop_cmd        = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (mpfd_pkg::QPTR_W+1)'(mpfd_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/mpfd_engine.sv =====
module mpfd_engine #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64,
   parameter int STORE_SIZE   = 1024,
   parameter int ADDR_W       = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mpfd_pkg::q_status_type q_status,
   input  mpfd_pkg::cmd_type      q_cmd,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_read_data
);

   logic [7:0] frame_mem [STORE_SIZE];

   mpfd_pkg::eng_state_type state_ff, state_in;
   mpfd_pkg::cmd_type       cmd_ff, cmd_in;
   logic [7:0]              cur_x_ff, cur_x_in;
   logic [7:0]              cur_y_ff, cur_y_in;
   logic [7:0]              cnt_i_ff, cnt_i_in;
   logic [7:0]              cnt_j_ff, cnt_j_in;
   logic [1:0]              phase_ff, phase_in;
   logic signed [mpfd_pkg::ERR_W-1:0] err_ff, err_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [7:0]              mask_ff, mask_in;
   logic [7:0]              rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       waddr, raddr;
   logic [7:0]              wdata;
   logic                    advance;

   logic                    gen_last;
   logic [7:0]              nx_x, nx_y, nx_i, nx_j;
   logic [1:0]              nx_phase;
   logic signed [mpfd_pkg::ERR_W-1:0] nx_err;

   logic                    on_panel;
   logic [mpfd_pkg::WIDE_ADDR_W-1:0] wide_addr;
   logic [ADDR_W-1:0]       pix_addr;
   logic [7:0]              pix_mask;
   logic                    sweep_last;

   assign clearing      = (state_ff == mpfd_pkg::ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   assign on_panel  = ({1'b0, cur_x_ff} < 9'(PANEL_WIDTH)) &&
                      ({1'b0, cur_y_ff} < 9'(PANEL_HEIGHT));
   assign wide_addr = mpfd_pkg::WIDE_ADDR_W'(cur_y_ff[7:3]) *
                      mpfd_pkg::WIDE_ADDR_W'(PANEL_WIDTH) +
                      mpfd_pkg::WIDE_ADDR_W'(cur_x_ff);
   assign pix_addr  = ADDR_W'(wide_addr);
   assign pix_mask  = 8'd1 << cur_y_ff[2:0];
   assign sweep_last = (sweep_ff == ADDR_W'(STORE_SIZE - 1));

   // next pixel of the current shape
   always_comb begin
      logic signed [mpfd_pkg::ERR_W:0]   e2;
      logic signed [mpfd_pkg::ERR_W:0]   dx_s;
      logic signed [mpfd_pkg::ERR_W:0]   dy_s;
      logic                              step_x, step_y, run_end;
      e2       = {err_ff, 1'b0};
      dx_s     = $signed({4'b0, cmd_ff.dx});
      dy_s     = -$signed({4'b0, cmd_ff.dym});
      step_x   = 1'b0;
      step_y   = 1'b0;
      run_end  = 1'b0;
      gen_last = 1'b1;
      nx_x     = cur_x_ff;
      nx_y     = cur_y_ff;
      nx_i     = cnt_i_ff;
      nx_j     = cnt_j_ff;
      nx_phase = phase_ff;
      nx_err   = err_ff;
      unique case (cmd_ff.op)
         mpfd_pkg::OP_LINE: begin
            gen_last = (cur_x_ff == cmd_ff.xe) && (cur_y_ff == cmd_ff.ye);
            step_x   = (e2 >= dy_s);
            step_y   = (e2 <= dx_s);
            nx_err   = err_ff + (step_x ? dy_s[mpfd_pkg::ERR_W-1:0] : '0)
                              + (step_y ? dx_s[mpfd_pkg::ERR_W-1:0] : '0);
            if (step_x) begin
               nx_x = cmd_ff.sx_neg ? cur_x_ff - 8'd1 : cur_x_ff + 8'd1;
            end
            if (step_y) begin
               nx_y = cmd_ff.sy_neg ? cur_y_ff - 8'd1 : cur_y_ff + 8'd1;
            end
         end
         mpfd_pkg::OP_OUTLINE: begin
            run_end  = phase_ff[1] ? (cnt_i_ff == cmd_ff.h - 8'd1)
                                   : (cnt_i_ff == cmd_ff.w - 8'd1);
            gen_last = run_end && (phase_ff == 2'd3);
            if (!run_end) begin
               nx_i = cnt_i_ff + 8'd1;
               if (phase_ff[1]) begin
                  nx_y = cur_y_ff + 8'd1;
               end else begin
                  nx_x = cur_x_ff + 8'd1;
               end
            end else begin
               nx_i     = 8'd0;
               nx_phase = phase_ff + 2'd1;
               unique case (phase_ff)
                  2'd0: begin
                     nx_x = cmd_ff.x;
                     nx_y = cmd_ff.y + cmd_ff.h - 8'd1;
                  end
                  2'd1: begin
                     nx_x = cmd_ff.x;
                     nx_y = cmd_ff.y;
                  end
                  2'd2: begin
                     nx_x = cmd_ff.x + cmd_ff.w - 8'd1;
                     nx_y = cmd_ff.y;
                  end
                  default: begin
                     nx_x = cur_x_ff;
                     nx_y = cur_y_ff;
                  end
               endcase
            end
         end
         mpfd_pkg::OP_SOLID: begin
            run_end  = (cnt_i_ff == cmd_ff.w - 8'd1);
            gen_last = run_end && (cnt_j_ff == cmd_ff.h - 8'd1);
            if (!run_end) begin
               nx_i = cnt_i_ff + 8'd1;
               nx_x = cur_x_ff + 8'd1;
            end else begin
               nx_i = 8'd0;
               nx_j = cnt_j_ff + 8'd1;
               nx_x = cmd_ff.x;
               nx_y = cur_y_ff + 8'd1;
            end
         end
         default: gen_last = 1'b1;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cnt_i_in     = cnt_i_ff;
      cnt_j_in     = cnt_j_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      sweep_in     = sweep_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      waddr        = sweep_ff;
      raddr        = pix_addr;
      wdata        = 8'h00;
      pop          = 1'b0;
      advance      = 1'b0;
      unique case (state_ff)
         mpfd_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = mpfd_pkg::ST_IDLE;
            end
         end
         mpfd_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cmd_in   = q_cmd;
               cur_x_in = q_cmd.x;
               cur_y_in = q_cmd.y;
               cnt_i_in = 8'd0;
               cnt_j_in = 8'd0;
               phase_in = 2'd0;
               err_in   = mpfd_pkg::ERR_W'({3'b0, q_cmd.dx}) -
                          mpfd_pkg::ERR_W'({3'b0, q_cmd.dym});
               sweep_in = '0;
               unique case (q_cmd.op)
                  mpfd_pkg::OP_FILL:    state_in = mpfd_pkg::ST_FILL;
                  mpfd_pkg::OP_PIXEL,
                  mpfd_pkg::OP_LINE,
                  mpfd_pkg::OP_OUTLINE,
                  mpfd_pkg::OP_SOLID:   state_in = mpfd_pkg::ST_PIX_RD;
                  mpfd_pkg::OP_READ:    state_in = mpfd_pkg::ST_READ;
                  default:              state_in = mpfd_pkg::ST_RESP;
               endcase
            end
         end
         mpfd_pkg::ST_FILL: begin
            mem_we   = 1'b1;
            wdata    = cmd_ff.pat;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = mpfd_pkg::ST_RESP;
            end
         end
         mpfd_pkg::ST_PIX_RD: begin
            if (on_panel) begin
               mem_re   = 1'b1;
               addr_in  = pix_addr;
               mask_in  = pix_mask;
               state_in = mpfd_pkg::ST_PIX_WR;
            end else begin
               advance  = 1'b1;
               state_in = gen_last ? mpfd_pkg::ST_RESP : mpfd_pkg::ST_PIX_RD;
            end
         end
         mpfd_pkg::ST_PIX_WR: begin
            mem_we   = 1'b1;
            waddr    = addr_ff;
            wdata    = cmd_ff.on ? (rd_data_ff | mask_ff) : (rd_data_ff & ~mask_ff);
            advance  = 1'b1;
            state_in = gen_last ? mpfd_pkg::ST_RESP : mpfd_pkg::ST_PIX_RD;
         end
         mpfd_pkg::ST_READ: begin
            mem_re   = 1'b1;
            raddr    = ADDR_W'(cmd_ff.ridx);
            state_in = mpfd_pkg::ST_RESP;
         end
         mpfd_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (cmd_ff.op == mpfd_pkg::OP_READ) ? rd_data_ff : 8'h00;
               state_in     = mpfd_pkg::ST_IDLE;
            end
         end
         default: state_in = mpfd_pkg::ST_IDLE;
      endcase
      if (advance) begin
         cur_x_in = nx_x;
         cur_y_in = nx_y;
         cnt_i_in = nx_i;
         cnt_j_in = nx_j;
         phase_in = nx_phase;
         err_in   = nx_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpfd_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cnt_i_ff    <= cnt_i_in;
      cnt_j_ff    <= cnt_j_in;
      phase_ff    <= phase_in;
      err_ff      <= err_in;
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[raddr];
      end
   end

endmodule

// ===== hw/rtl/mono_page_framebuffer_drawer.sv =====
// Channel | Ports                                   | Direction
// req     | req_valid/req_stall, req_type..index    | in, one command per beat
// rsp     | rsp_valid/rsp_stall, rsp_read_data      | out, one result per command
//
// A fill writes all STORE_SIZE bytes; a read returns one byte, a no-op zero.
// Pixel, line and rectangle do a read-modify-write of one frame memory byte
// per on-panel pixel and drop the pixels that fall off the panel.
// After reset the frame memory (STORE_SIZE bytes, 1024 by default) is swept
// to zero while req_stall stays high.
// Two commands queue ahead of the engine; a stalled result holds only the engine.
module mono_page_framebuffer_drawer #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [7:0] req_start_x,
   input  logic [7:0] req_start_y,
   input  logic [7:0] req_end_x,
   input  logic [7:0] req_end_y,
   input  logic [7:0] req_rect_width,
   input  logic [7:0] req_rect_height,
   input  logic       req_pixel_on,
   input  logic [7:0] req_fill_pattern,
   input  logic [9:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   localparam int STORE_SIZE = PANEL_WIDTH *
                               ((PANEL_HEIGHT + mpfd_pkg::PAGE_ROWS - 1) / mpfd_pkg::PAGE_ROWS);
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   mpfd_pkg::q_status_type q_status;
   mpfd_pkg::cmd_type      push_cmd;
   mpfd_pkg::cmd_type      pop_cmd;
   logic                   push;
   logic                   pop;
   logic                   clearing;

   mpfd_front #(
      .STORE_SIZE (STORE_SIZE)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_pixel_on     (req_pixel_on),
      .req_fill_pattern (req_fill_pattern),
      .req_read_index   (req_read_index),
      .q_status         (q_status),
      .clearing         (clearing),
      .push             (push),
      .cmd              (push_cmd)
   );

   mpfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   mpfd_engine #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .STORE_SIZE   (STORE_SIZE),
      .ADDR_W       (ADDR_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_cmd         (pop_cmd),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data)
   );

endmodule

// ===== hw/rtl/mpfd_checker.sv =====
module mpfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_data
);

   // no result can be pending right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // memory clear keeps the input side closed
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("command taken during post-reset clear");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_read_data))
      else $error("result data changed while stalled");

endmodule

bind mono_page_framebuffer_drawer mpfd_checker u_checker (.*);
